// File: sv/wlac_pkg.sv
// ----------------------------------------------------------------------------
// wlac_pkg
// Shared codes, constants and control types of the water level alarm controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wlac_pkg;

  // level classes, also used as poll period codes
  localparam logic [1:0] LVL_NORMAL = 2'd0;
  localparam logic [1:0] LVL_PRE    = 2'd1;
  localparam logic [1:0] LVL_ALARM  = 2'd2;

  localparam logic [7:0] FULL_ANGLE = 8'd180;

  // configuration register indexes
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PRE_ALARM = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ALARM     = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX       = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HOLD      = 2'd3;

  localparam int unsigned HOLD_BITS = 16;

  // servo map quotient is below 180, so eight quotient bits
  localparam int unsigned QUO_BITS = 8;
  localparam int unsigned STEP_CNT_BITS = $clog2(QUO_BITS);

  typedef struct packed {
    logic load;   // latch an accepted input transfer
    logic eval;   // classify and update controller state
    logic step;   // one restoring divider iteration
    logic emit;   // finish the angle and load the output register
  } cmd_t;

  typedef struct packed {
    logic can_emit;  // output register free or drained this cycle
  } stat_t;

endpackage

// File: sv/wlac_ctrl.sv
// ----------------------------------------------------------------------------
// wlac_ctrl
// Sequencer: accept, evaluate, eight divider steps, emit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wlac_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_tvalid_i,
  output logic            s_tready_o,
  input  wlac_pkg::stat_t stat_i,
  output wlac_pkg::cmd_t  cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  localparam logic [wlac_pkg::STEP_CNT_BITS-1:0] LAST_STEP =
    wlac_pkg::STEP_CNT_BITS'(wlac_pkg::QUO_BITS - 1);

  logic [1:0] state_q, state_d;
  logic [wlac_pkg::STEP_CNT_BITS-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        cnt_d      = '0;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == LAST_STEP) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // hold here while the previous result is still pending
        if (stat_i.can_emit) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// File: sv/wlac_datapath.sv
// ----------------------------------------------------------------------------
// wlac_datapath
// Configuration, controller state, servo map divider and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wlac_datapath #(
  parameter int unsigned DISTANCE_BITS = 10,
  parameter int unsigned TIME_BITS     = 32,
  parameter int unsigned WDATA_BITS    = 16,
  parameter int unsigned IN_BITS       = 56,
  parameter int unsigned OUT_BITS      = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [wlac_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [WDATA_BITS-1:0]             cfg_wdata_i,
  input  logic [IN_BITS-1:0]                s_tdata_i,
  input  logic                              s_tuser_i,
  input  wlac_pkg::cmd_t                    cmd_i,
  output wlac_pkg::stat_t                   stat_o,
  output logic                              m_tvalid_o,
  input  logic                              m_tready_i,
  output logic [OUT_BITS-1:0]               m_tdata_o
);

  localparam int unsigned DB = DISTANCE_BITS;
  localparam int unsigned TB = TIME_BITS;
  localparam int unsigned PB = DB + wlac_pkg::QUO_BITS;
  localparam int unsigned QB = wlac_pkg::QUO_BITS;
  localparam int unsigned PAYLOAD_BITS = 17 + DB;

  // configuration
  logic [DB-1:0] pre_q, alm_q, max_q;
  logic [wlac_pkg::HOLD_BITS-1:0] hold_q;

  // latched input
  logic [DB-1:0] dist_in_q;
  logic [TB-1:0] now_in_q;
  logic          rise_in_q;
  logic [7:0]    pot_in_q;

  // controller state
  logic [1:0]    level_q, level_d;
  logic [TB-1:0] entry_q, entry_d;
  logic [DB-1:0] held_q, held_d;
  logic manual_q, manual_d, armed_q, armed_d;
  logic led_b_q, led_b_d, led_c_q, led_c_d;
  logic light_q, light_d, vopen_q, vopen_d;
  logic [7:0] vangle_q, vangle_d;
  logic use_map_q, use_map_d;

  // divider
  logic [DB-1:0] rem_q, rem_d;
  logic [QB-1:0] quo_q, quo_d, shf_q, shf_d;

  // output register
  logic [OUT_BITS-1:0] out_data_q;
  logic                out_valid_q;

  logic [TB-1:0] elapsed;
  logic          holding;
  logic [DB-1:0] dist_eval;
  logic [PB-1:0] prod;
  logic [DB:0]   trial;
  logic [7:0]    angle_fin, angle_out;
  logic [DB-1:0] water;
  logic [PAYLOAD_BITS-1:0] payload;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_q  <= DB'(100);
      alm_q  <= DB'(50);
      max_q  <= DB'(200);
      hold_q <= wlac_pkg::HOLD_BITS'(100);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wlac_pkg::CFG_PRE_ALARM: pre_q  <= cfg_wdata_i[DB-1:0];
        wlac_pkg::CFG_ALARM:     alm_q  <= cfg_wdata_i[DB-1:0];
        wlac_pkg::CFG_MAX:       max_q  <= cfg_wdata_i[DB-1:0];
        wlac_pkg::CFG_HOLD:      hold_q <= cfg_wdata_i[wlac_pkg::HOLD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dist_in_q <= s_tdata_i[DB-1:0];
      now_in_q  <= s_tdata_i[DB+TB-1:DB];
      pot_in_q  <= s_tdata_i[DB+TB+7:DB+TB];
      rise_in_q <= s_tuser_i;
    end
  end

  assign elapsed   = now_in_q - entry_q;
  assign holding   = (level_q == wlac_pkg::LVL_ALARM) &&
                     (elapsed < TB'(hold_q));
  assign dist_eval = holding ? held_q : dist_in_q;
  assign prod      = PB'(dist_eval) * PB'(wlac_pkg::FULL_ANGLE);
  assign trial     = {rem_q, shf_q[QB-1]};

  always_comb begin
    level_d   = level_q;
    entry_d   = entry_q;
    held_d    = held_q;
    manual_d  = manual_q;
    armed_d   = armed_q;
    led_b_d   = led_b_q;
    led_c_d   = led_c_q;
    light_d   = light_q;
    vopen_d   = vopen_q;
    vangle_d  = vangle_q;
    use_map_d = use_map_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    shf_d     = shf_q;

    if (cmd_i.eval) begin
      // button toggle comes first
      if (rise_in_q && armed_q) begin
        manual_d = !manual_q;
        armed_d  = 1'b0;
      end
      use_map_d = 1'b0;
      rem_d     = prod[PB-1:QB];
      shf_d     = prod[QB-1:0];
      if (!holding) begin
        held_d = dist_in_q;
      end
      if (!holding && (dist_in_q > pre_q || dist_in_q > alm_q)) begin
        if (dist_in_q > pre_q) begin
          level_d = wlac_pkg::LVL_NORMAL;
          led_b_d = 1'b1;
          led_c_d = 1'b0;
        end else begin
          level_d = wlac_pkg::LVL_PRE;
          led_b_d = 1'b0;
          led_c_d = !led_c_q;
        end
        // leaving alarm
        if (level_q == wlac_pkg::LVL_ALARM) begin
          armed_d  = 1'b0;
          light_d  = 1'b1;
          vopen_d  = 1'b0;
          vangle_d = '0;
          manual_d = 1'b0;
        end
      end else begin
        if (!holding) begin
          level_d = wlac_pkg::LVL_ALARM;
          entry_d = now_in_q;
        end
        light_d = 1'b0;
        led_b_d = 1'b0;
        led_c_d = 1'b1;
        armed_d = 1'b1;
        vopen_d = 1'b1;
        if (manual_d) begin
          vangle_d = (pot_in_q > wlac_pkg::FULL_ANGLE) ? wlac_pkg::FULL_ANGLE : pot_in_q;
        end else if (dist_eval < alm_q) begin
          use_map_d = 1'b1;
        end else begin
          vangle_d = wlac_pkg::FULL_ANGLE;
        end
      end
    end

    if (cmd_i.step) begin
      // restoring division of distance*180 by alarm_distance
      if (trial >= {1'b0, alm_q}) begin
        rem_d = DB'(trial - {1'b0, alm_q});
        quo_d = {quo_q[QB-2:0], 1'b1};
      end else begin
        rem_d = trial[DB-1:0];
        quo_d = {quo_q[QB-2:0], 1'b0};
      end
      shf_d = {shf_q[QB-2:0], 1'b0};
    end

    if (cmd_i.emit) begin
      vangle_d  = angle_fin;
      use_map_d = 1'b0;
    end
  end

  assign angle_fin = use_map_q ? (wlac_pkg::FULL_ANGLE - quo_q) : vangle_q;
  assign angle_out = vopen_q ? angle_fin : 8'd0;
  assign water     = (held_q < max_q) ? (max_q - held_q) : '0;
  assign payload   = {level_q, water, manual_q, angle_out, vopen_q,
                      light_q, led_c_q, led_b_q, level_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q   <= wlac_pkg::LVL_NORMAL;
      entry_q   <= '0;
      held_q    <= '0;
      manual_q  <= 1'b0;
      armed_q   <= 1'b0;
      led_b_q   <= 1'b0;
      led_c_q   <= 1'b0;
      light_q   <= 1'b1;
      vopen_q   <= 1'b0;
      vangle_q  <= '0;
      use_map_q <= 1'b0;
    end else begin
      level_q   <= level_d;
      entry_q   <= entry_d;
      held_q    <= held_d;
      manual_q  <= manual_d;
      armed_q   <= armed_d;
      led_b_q   <= led_b_d;
      led_c_q   <= led_c_d;
      light_q   <= light_d;
      vopen_q   <= vopen_d;
      vangle_q  <= vangle_d;
      use_map_q <= use_map_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    shf_q <= shf_d;
    if (cmd_i.emit) begin
      out_data_q <= OUT_BITS'(payload);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign stat_o.can_emit = !out_valid_q || m_tready_i;
  assign m_tvalid_o      = out_valid_q;
  assign m_tdata_o       = out_data_q;

endmodule

// File: sv/water_level_alarm_controller_core.sv
// ----------------------------------------------------------------------------
// water_level_alarm_controller_core
// Classifies sonar polls into normal, pre-alarm and alarm and drives LEDs,
// light enable and the valve servo.
// ----------------------------------------------------------------------------
// One poll enters on the s_ stream (distance, time, pot angle in tdata,
// button rise in tuser) and one result leaves on the m_ stream.
// Thresholds, empty-channel distance and alarm hold time are written on the
// cfg_ port while the block is idle; the user must keep to this, the block
// itself does no such check. A poll runs from accept through an
// evaluation state, eight restoring divider steps for the servo map (one
// quotient bit per step) and an emit state that loads the output register,
// whose result shows on m_tvalid_o in the cycle after the emit state.
// The output register parts the two sides: the next poll is taken while a
// result waits; if the receiver stalls longer, the block waits before its
// emit cycle and holds s_tready_o low.
// Reset loads the default thresholds, clears the class to normal, closes
// the valve and enables the light.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module water_level_alarm_controller_core #(
  parameter int unsigned DISTANCE_BITS = 10,
  parameter int unsigned TIME_BITS     = 32,
  localparam int unsigned WDATA_BITS =
    (DISTANCE_BITS > wlac_pkg::HOLD_BITS) ? DISTANCE_BITS : wlac_pkg::HOLD_BITS,
  localparam int unsigned IN_BITS  = ((DISTANCE_BITS + TIME_BITS + 8 + 7) / 8) * 8,
  localparam int unsigned OUT_BITS = ((DISTANCE_BITS + 17 + 7) / 8) * 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [wlac_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [WDATA_BITS-1:0]             cfg_wdata_i,
  input  logic                              s_tvalid_i,
  output logic                              s_tready_o,
  // distance, now_ms, pot_angle
  input  logic [IN_BITS-1:0]                s_tdata_i,
  // button_rise
  input  logic                              s_tuser_i,
  output logic                              m_tvalid_o,
  input  logic                              m_tready_i,
  // level_code, led_b, led_c, light_active, servo_open, servo_angle,
  // manual_active, water_level, poll_period_code
  output logic [OUT_BITS-1:0]               m_tdata_o
);

  wlac_pkg::cmd_t  cmd;
  wlac_pkg::stat_t stat;

  wlac_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  wlac_datapath #(
    .DISTANCE_BITS (DISTANCE_BITS),
    .TIME_BITS     (TIME_BITS),
    .WDATA_BITS    (WDATA_BITS),
    .IN_BITS       (IN_BITS),
    .OUT_BITS      (OUT_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o)
  );

endmodule

// File: test/wlac_poll_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlac_poll_checker
// Watches the config port and both streams of the water level alarm
// controller. Keeps its own copy of the thresholds and of the controller
// state, predicts one result per accepted poll and compares every result
// transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------

module wlac_poll_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [wlac_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [15:0]                       cfg_wdata_i,
  input  logic                              s_tvalid_i,
  input  logic                              s_tready_i,
  // distance, now_ms, pot_angle
  input  logic [55:0]                       s_tdata_i,
  // button_rise
  input  logic                              s_tuser_i,
  input  logic                              m_tvalid_i,
  input  logic                              m_tready_i,
  // level_code, led_b, led_c, light_active, servo_open, servo_angle,
  // manual_active, water_level, poll_period_code
  input  logic [31:0]                       m_tdata_i,
  output int unsigned                       fail_count_o,
  output int unsigned                       outstanding_o
);

  // last member sits in the lowest bits, matching the m_tdata layout
  typedef struct packed {
    logic [1:0] poll_period;
    logic [9:0] water_level;
    logic       manual_active;
    logic [7:0] servo_angle;
    logic       servo_open;
    logic       light_active;
    logic       led_c;
    logic       led_b;
    logic [1:0] level;
  } poll_result_t;

  logic [9:0]  pre_alarm_dist;
  logic [9:0]  alarm_dist;
  logic [9:0]  max_dist;
  logic [15:0] hold_ms;

  logic [1:0]  level_state;
  logic [31:0] alarm_entry_ms;
  logic [9:0]  held_distance;
  logic        manual_mode;
  logic        button_armed;
  logic        led_b_on;
  logic        led_c_on;
  logic        light_enabled;
  logic        valve_open;
  logic [7:0]  valve_angle;

  poll_result_t pending_poll_results[$];
  int unsigned  fails;

  function automatic void apply_alarm(logic [7:0] pot);
    int unsigned num;
    int unsigned den;
    int unsigned scaled;
    light_enabled = 1'b0;
    led_b_on      = 1'b0;
    led_c_on      = 1'b1;
    button_armed  = 1'b1;
    valve_open    = 1'b1;
    if (manual_mode) begin
      valve_angle = (pot > wlac_pkg::FULL_ANGLE) ? wlac_pkg::FULL_ANGLE : pot;
    end else if (held_distance < alarm_dist) begin
      num    = 32'(held_distance);
      den    = 32'(alarm_dist);
      scaled = (num * 180) / den;
      valve_angle = wlac_pkg::FULL_ANGLE - scaled[7:0];
    end else begin
      valve_angle = wlac_pkg::FULL_ANGLE;
    end
  endfunction

  function automatic poll_result_t predict_poll_result(logic [9:0] distance,
                                                       logic [31:0] now,
                                                       logic rise,
                                                       logic [7:0] pot);
    poll_result_t res;
    logic [1:0]   prev_level;
    logic [31:0]  elapsed;
    if (rise && button_armed) begin
      manual_mode  = !manual_mode;
      button_armed = 1'b0;
    end
    // wrapping subtraction, a zero hold never holds
    elapsed = now - alarm_entry_ms;
    if (level_state == wlac_pkg::LVL_ALARM && elapsed < {16'd0, hold_ms}) begin
      apply_alarm(pot);
    end else begin
      prev_level    = level_state;
      held_distance = distance;
      if (distance > pre_alarm_dist) begin
        level_state = wlac_pkg::LVL_NORMAL;
        led_b_on    = 1'b1;
        led_c_on    = 1'b0;
      end else if (distance > alarm_dist) begin
        level_state = wlac_pkg::LVL_PRE;
        led_b_on    = 1'b0;
        led_c_on    = !led_c_on;
      end else begin
        level_state    = wlac_pkg::LVL_ALARM;
        alarm_entry_ms = now;
        apply_alarm(pot);
      end
      // leaving alarm drops manual control and closes the valve
      if (prev_level == wlac_pkg::LVL_ALARM && level_state != wlac_pkg::LVL_ALARM) begin
        button_armed  = 1'b0;
        light_enabled = 1'b1;
        valve_open    = 1'b0;
        valve_angle   = 8'd0;
        manual_mode   = 1'b0;
      end
    end
    res.level         = level_state;
    res.led_b         = led_b_on;
    res.led_c         = led_c_on;
    res.light_active  = light_enabled;
    res.servo_open    = valve_open;
    res.servo_angle   = valve_open ? valve_angle : 8'd0;
    res.manual_active = manual_mode;
    res.water_level   = (held_distance < max_dist) ? max_dist - held_distance : 10'd0;
    res.poll_period   = level_state;
    return res;
  endfunction

  task automatic report_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    poll_result_t exp_r;
    poll_result_t act_r;
    if (!rst_ni) begin
      pre_alarm_dist = 10'd100;
      alarm_dist     = 10'd50;
      max_dist       = 10'd200;
      hold_ms        = 16'd100;
      level_state    = wlac_pkg::LVL_NORMAL;
      alarm_entry_ms = '0;
      held_distance  = '0;
      manual_mode    = 1'b0;
      button_armed   = 1'b0;
      led_b_on       = 1'b0;
      led_c_on       = 1'b0;
      light_enabled  = 1'b1;
      valve_open     = 1'b0;
      valve_angle    = '0;
      pending_poll_results.delete();
      fails          = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          wlac_pkg::CFG_PRE_ALARM: pre_alarm_dist = cfg_wdata_i[9:0];
          wlac_pkg::CFG_ALARM:     alarm_dist     = cfg_wdata_i[9:0];
          wlac_pkg::CFG_MAX:       max_dist       = cfg_wdata_i[9:0];
          wlac_pkg::CFG_HOLD:      hold_ms        = cfg_wdata_i;
          default: ;
        endcase
      end
      if (m_tvalid_i && m_tready_i) begin
        if (pending_poll_results.size() == 0) begin
          $display("%0t: result transfer with nothing expected, actual %h",
                   $time, m_tdata_i);
          fails++;
        end else begin
          exp_r = pending_poll_results.pop_front();
          act_r = poll_result_t'(m_tdata_i[26:0]);
          if (act_r !== exp_r) begin
            report_field("level_code", 32'(exp_r.level), 32'(act_r.level));
            report_field("led_b", 32'(exp_r.led_b), 32'(act_r.led_b));
            report_field("led_c", 32'(exp_r.led_c), 32'(act_r.led_c));
            report_field("light_active", 32'(exp_r.light_active),
                         32'(act_r.light_active));
            report_field("servo_open", 32'(exp_r.servo_open), 32'(act_r.servo_open));
            report_field("servo_angle", 32'(exp_r.servo_angle), 32'(act_r.servo_angle));
            report_field("manual_active", 32'(exp_r.manual_active),
                         32'(act_r.manual_active));
            report_field("water_level", 32'(exp_r.water_level), 32'(act_r.water_level));
            report_field("poll_period_code", 32'(exp_r.poll_period),
                         32'(act_r.poll_period));
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        pending_poll_results.push_back(predict_poll_result(s_tdata_i[9:0],
                                                           s_tdata_i[41:10],
                                                           s_tuser_i,
                                                           s_tdata_i[49:42]));
      end
    end
    outstanding_o <= pending_poll_results.size();
    fail_count_o  <= fails;
  end

endmodule

// File: test/tb_water_level_alarm_controller_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_water_level_alarm_controller_core
// Drives sonar polls into the water level alarm controller: a directed
// opening over thresholds, alarm hold, button and pot corners, then random
// polls over several threshold settings with random idle bursts on both
// streams. Result checking lives in wlac_poll_checker.
// ----------------------------------------------------------------------------

module tb_water_level_alarm_controller_core;

  localparam int unsigned LIMIT        = 500000;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_POLLS  = 250;
  localparam int unsigned DRAIN_CYCLES = 16;

  logic                              clk_i       = 1'b0;
  logic                              rst_ni      = 1'b0;
  logic                              cfg_we_i    = 1'b0;
  logic [wlac_pkg::CFG_IDX_BITS-1:0] cfg_idx_i   = wlac_pkg::CFG_PRE_ALARM;
  logic [15:0]                       cfg_wdata_i = '0;
  logic                              s_tvalid_i  = 1'b0;
  logic                              s_tready_o;
  logic [55:0]                       s_tdata_i   = '0;
  logic                              s_tuser_i   = 1'b0;
  logic                              m_tvalid_o;
  logic                              m_tready_i  = 1'b0;
  logic [31:0]                       m_tdata_o;

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned cycle_count = 0;
  int unsigned ready_burst = 0;
  logic        calm        = 1'b0;

  // thresholds currently programmed, used to aim the random distances
  int unsigned pre_cfg  = 100;
  int unsigned alarm_cfg = 50;
  int unsigned max_cfg  = 200;
  int unsigned hold_cfg = 100;
  logic [31:0] now_ms   = 32'd1000;

  water_level_alarm_controller_core #(
    .DISTANCE_BITS(10),
    .TIME_BITS    (32)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

  wlac_poll_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_tvalid_i   (s_tvalid_i),
    .s_tready_i   (s_tready_o),
    .s_tdata_i    (s_tdata_i),
    .s_tuser_i    (s_tuser_i),
    .m_tvalid_i   (m_tvalid_o),
    .m_tready_i   (m_tready_i),
    .m_tdata_i    (m_tdata_o),
    .fail_count_o (fail_count),
    .outstanding_o(outstanding)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // receiver holds random ready or stall bursts, always ready when calm
  always @(posedge clk_i) begin
    if (calm) begin
      m_tready_i <= 1'b1;
    end else if (ready_burst == 0) begin
      m_tready_i  <= ($urandom_range(0, 1) == 1);
      ready_burst <= $urandom_range(1, 16);
    end else begin
      ready_burst <= ready_burst - 1;
    end
  end

  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  task automatic send_poll(logic [9:0] distance, logic [31:0] now, logic rise,
                           logic [7:0] pot);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= {6'd0, pot, now, distance};
    s_tuser_i  <= rise;
    // ready is sampled mid-cycle, the transfer happens at the next edge
    do @(negedge clk_i); while (!s_tready_o);
    @(posedge clk_i);
  endtask

  task automatic settle_idle();
    s_tvalid_i <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [wlac_pkg::CFG_IDX_BITS-1:0] idx, logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
  endtask

  task automatic configure(int unsigned pre_d, int unsigned alarm_d, int unsigned max_d,
                           int unsigned hold);
    write_cfg(wlac_pkg::CFG_PRE_ALARM, pre_d[15:0]);
    write_cfg(wlac_pkg::CFG_ALARM, alarm_d[15:0]);
    write_cfg(wlac_pkg::CFG_MAX, max_d[15:0]);
    write_cfg(wlac_pkg::CFG_HOLD, hold[15:0]);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    pre_cfg   = pre_d;
    alarm_cfg = alarm_d;
    max_cfg   = max_d;
    hold_cfg  = hold;
  endtask

  function automatic logic [9:0] clamp_distance(int value);
    if (value < 0) return 10'd0;
    if (value > 1023) return 10'd1023;
    return value[9:0];
  endfunction

  task automatic random_poll();
    logic [9:0] distance;
    logic [7:0] pot;
    case ($urandom_range(0, 9))
      0:       distance = 10'($urandom_range(0, 1023));
      1, 2:    distance = clamp_distance(int'(pre_cfg) + int'($urandom_range(0, 4)) - 2);
      3, 4:    distance = clamp_distance(int'(alarm_cfg) + int'($urandom_range(0, 4)) - 2);
      5, 6:    distance = 10'($urandom_range(0, alarm_cfg));
      7:       distance = ($urandom_range(0, 1) == 1) ? 10'd1023 : 10'd0;
      8:       distance = clamp_distance(int'(max_cfg) + int'($urandom_range(0, 4)) - 2);
      default: distance = 10'($urandom_range(0, pre_cfg));
    endcase
    // time mostly runs forward, with steps aimed at the hold edge
    case ($urandom_range(0, 9))
      0: begin
        if ($urandom_range(0, 1) == 1) now_ms = $urandom;
        else now_ms = 32'hFFFF_FF00 + $urandom_range(0, 255);
      end
      1:       now_ms = now_ms + hold_cfg - 1;
      2:       now_ms = now_ms + hold_cfg;
      3:       now_ms = now_ms + hold_cfg + 1;
      4:       now_ms = now_ms;
      default: now_ms = now_ms + $urandom_range(0, hold_cfg / 4 + 2);
    endcase
    if ($urandom_range(0, 9) == 0) pot = 8'($urandom_range(181, 255));
    else pot = 8'($urandom_range(0, 180));
    send_poll(distance, now_ms, ($urandom_range(0, 2) == 0), pot);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset thresholds: 100 / 50 / 200, hold 100
    send_poll(10'd1023, 32'd1000, 1'b0, 8'd0);
    send_poll(10'd101,  32'd1001, 1'b1, 8'd0);    // rise while disarmed
    send_poll(10'd100,  32'd1002, 1'b0, 8'd0);    // pre-alarm, red on
    send_poll(10'd51,   32'd1003, 1'b0, 8'd0);    // red toggles off
    send_poll(10'd50,   32'd1010, 1'b0, 8'd0);    // alarm at threshold
    send_poll(10'd1023, 32'd1050, 1'b1, 8'd90);   // held, manual on
    send_poll(10'd0,    32'd1109, 1'b0, 8'd255);  // pot saturates
    send_poll(10'd1023, 32'd1110, 1'b0, 8'd180);  // hold ends exactly
    send_poll(10'd0,    32'd1200, 1'b0, 8'd0);
    send_poll(10'd25,   32'd1250, 1'b0, 8'd0);    // held distance reused
    send_poll(10'd25,   32'd1300, 1'b0, 8'd0);    // re-entry, mapped angle
    send_poll(10'd49,   32'd1400, 1'b0, 8'd0);
    send_poll(10'd49,   32'd1500, 1'b1, 8'd0);    // manual at zero degrees
    send_poll(10'd10,   32'hFFFF_FFC0, 1'b0, 8'd128);
    send_poll(10'd1023, 32'h0000_0010, 1'b1, 8'd128); // hold across wrap
    send_poll(10'd1023, 32'h0000_0030, 1'b0, 8'd0);
    send_poll(10'd300,  32'h0000_0031, 1'b1, 8'd0);

    // crossed thresholds, zero hold, zero empty distance
    settle_idle();
    configure(40, 200, 0, 0);
    send_poll(10'd100, 32'd10, 1'b0, 8'd0);
    send_poll(10'd30,  32'd11, 1'b0, 8'd0);
    send_poll(10'd30,  32'd11, 1'b1, 8'd77);
    send_poll(10'd0,   32'd12, 1'b0, 8'd77);
    send_poll(10'd1023, 32'd12, 1'b0, 8'd0);

    for (int p = 0; p < PHASES; p++) begin
      settle_idle();
      case (p)
        0: configure(100, 50, 200, 100);
        1: configure(300, 120, 600, 500);
        2: configure(1023, 1023, 1023, 65535);
        3: configure(0, 0, 0, 0);
        4: configure(40, 200, 1023, 30);
        5, 6: configure($urandom_range(0, 1023), $urandom_range(0, 1023),
                        $urandom_range(0, 1023), $urandom_range(0, 2000));
        default: configure(512, 511, 1000, 1);
      endcase
      if (p == PHASES - 1) calm = 1'b1;
      repeat (PHASE_POLLS) random_poll();
    end

    s_tvalid_i <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
